[hw/rtl/mlq_pkg.sv]
// Package for the multi-level linked task queue.
// Holds the sizes, command and status codes, and the controller/datapath structs.
// No dependencies.
package mlq_pkg;

   localparam int NUM_LEVELS = 8;
   localparam int NUM_NODES  = 16;

   localparam int CMD_W    = 3;
   localparam int LEVEL_W  = 3;
   localparam int NODE_W   = 4;
   localparam int STATUS_W = 2;
   localparam int LVOUT_W  = 4;

   localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int FOUND_W = $clog2(NUM_LEVELS + 1);
   localparam int PTR_W   = $clog2(NUM_NODES + 1);
   localparam int IDX_W   = $clog2(NUM_NODES);
   localparam int CNT_W   = $clog2(NUM_NODES + 1);

   localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_NODES);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_TAIL = 3'd0,
      CMD_PUSH_HEAD = 3'd1,
      CMD_POP_HEAD  = 3'd2,
      CMD_POP_TAIL  = 3'd3,
      CMD_ROTATE    = 3'd4,
      CMD_REMOVE    = 3'd5,
      CMD_PEEK_HIGH = 3'd6,
      CMD_POP_HIGH  = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_REFUSED = 2'd1,
      STATUS_EMPTY   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PUSH_TAIL,
      OP_PUSH_HEAD,
      OP_TAKE,
      OP_POP_ONLY,
      OP_ROTATE,
      OP_STEP,
      OP_CUT_TAIL,
      OP_UNLINK,
      OP_SCAN,
      OP_PEEK
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       rsp_valid;
      status_type rsp_status;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    lv_ok;
      logic    node_ok;
      logic    node_eq_tail;
      logic    head_nil;
      logic    tail_nil;
      logic    head_eq_tail;
      logic    cur_nil;
      logic    cur_eq_node;
      logic    lnk_eq_tail;
      logic    prev_nil;
      logic    cnt_done;
      logic    scan_hit;
   } dp_stat_type;

endpackage

[hw/rtl/mlq_datapath.sv]
// Datapath of the multi-level linked task queue: head, tail and link stores,
// walk pointers and the result register. Driven by mlq_controller; uses mlq_pkg.
module mlq_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [mlq_pkg::CMD_W-1:0]    req_cmd,
   input  logic [mlq_pkg::LEVEL_W-1:0]  req_queue_level,
   input  logic [mlq_pkg::NODE_W-1:0]   req_node_id,
   input  mlq_pkg::ctrl_cmd_type        ctrl,
   output mlq_pkg::dp_stat_type         stat,
   output logic                         rsp_strobe,
   output logic [mlq_pkg::STATUS_W-1:0] rsp_status,
   output logic [mlq_pkg::NODE_W-1:0]   rsp_node_out,
   output logic [mlq_pkg::LVOUT_W-1:0]  rsp_level_out
);

   localparam int PW = mlq_pkg::PTR_W;
   localparam int LW = mlq_pkg::LVL_W;
   localparam int IW = mlq_pkg::IDX_W;

   logic [PW-1:0] head_ff [mlq_pkg::NUM_LEVELS];
   logic [PW-1:0] head_in [mlq_pkg::NUM_LEVELS];
   logic [PW-1:0] tail_ff [mlq_pkg::NUM_LEVELS];
   logic [PW-1:0] tail_in [mlq_pkg::NUM_LEVELS];
   logic [PW-1:0] link_ff [mlq_pkg::NUM_NODES];

   mlq_pkg::cmd_type             cmd_ff, cmd_in;
   logic [LW-1:0]                lvl_ff, lvl_in;
   logic                         lv_ok_ff, lv_ok_in;
   logic [mlq_pkg::NODE_W-1:0]   node_ff, node_in;
   logic [PW-1:0]                cur_ff, cur_in;
   logic [PW-1:0]                prev_ff, prev_in;
   logic [mlq_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PW-1:0]                res_ff, res_in;
   logic [mlq_pkg::FOUND_W-1:0]  found_ff, found_in;

   logic                         strobe_ff;
   mlq_pkg::status_type          status_ff;
   logic [mlq_pkg::NODE_W-1:0]   node_out_ff;
   logic [mlq_pkg::LVOUT_W-1:0]  level_out_ff;

   logic          wa_en, wb_en;
   logic [PW-1:0] wa_addr, wa_data, wb_addr, wb_data;

   logic [PW-1:0] head_sel, tail_sel, lnk, node_p, link_raw;
   logic          node_ok;
   logic          req_lv_ok;
   logic [LW-1:0] req_lvl;
   logic          scan_hit;
   logic [LW-1:0] scan_idx;

   assign head_sel = head_ff[lvl_ff];
   assign tail_sel = tail_ff[lvl_ff];
   assign node_ok  = 32'(node_ff) < mlq_pkg::NUM_NODES;
   assign node_p   = node_ok ? PW'(node_ff) : mlq_pkg::NIL;
   assign link_raw = link_ff[cur_ff[IW-1:0]];
   assign lnk      = (cur_ff < mlq_pkg::NIL && link_raw < mlq_pkg::NIL) ? link_raw
                                                                       : mlq_pkg::NIL;
   assign req_lv_ok = 32'(req_queue_level) < mlq_pkg::NUM_LEVELS;
   assign req_lvl   = req_lv_ok ? LW'(req_queue_level) : '0;

   always_comb begin
      scan_hit = 1'b0;
      scan_idx = '0;
      for (int i = mlq_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
         if (head_ff[i] != mlq_pkg::NIL) begin
            scan_hit = 1'b1;
            scan_idx = LW'(i);
         end
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      cmd_in   = cmd_ff;
      lvl_in   = lvl_ff;
      lv_ok_in = lv_ok_ff;
      node_in  = node_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      found_in = found_ff;
      wa_en    = 1'b0;
      wa_addr  = cur_ff;
      wa_data  = mlq_pkg::NIL;
      wb_en    = 1'b0;
      wb_addr  = cur_ff;
      wb_data  = mlq_pkg::NIL;
      unique case (ctrl.op)
         mlq_pkg::OP_LOAD: begin
            cmd_in   = mlq_pkg::cmd_type'(req_cmd);
            lvl_in   = req_lvl;
            lv_ok_in = req_lv_ok;
            node_in  = req_node_id;
            cur_in   = req_lv_ok ? head_ff[req_lvl] : mlq_pkg::NIL;
            prev_in  = mlq_pkg::NIL;
            cnt_in   = '0;
            res_in   = mlq_pkg::NIL;
            found_in = '0;
         end
         mlq_pkg::OP_PUSH_TAIL: begin
            if (head_sel == mlq_pkg::NIL) begin
               head_in[lvl_ff] = node_p;
            end else begin
               wa_en   = 1'b1;
               wa_addr = tail_sel;
               wa_data = node_p;
            end
            tail_in[lvl_ff] = node_p;
            wb_en   = 1'b1;
            wb_addr = node_p;
            wb_data = mlq_pkg::NIL;
         end
         mlq_pkg::OP_PUSH_HEAD: begin
            wb_en   = 1'b1;
            wb_addr = node_p;
            wb_data = head_sel;
            head_in[lvl_ff] = node_p;
            if (tail_sel == mlq_pkg::NIL) begin
               tail_in[lvl_ff] = node_p;
            end
         end
         mlq_pkg::OP_TAKE: begin
            head_in[lvl_ff] = lnk;
            if (lnk == mlq_pkg::NIL) begin
               tail_in[lvl_ff] = mlq_pkg::NIL;
            end
            wb_en   = 1'b1;
            wb_addr = cur_ff;
            res_in  = cur_ff;
         end
         mlq_pkg::OP_POP_ONLY: begin
            res_in          = tail_sel;
            head_in[lvl_ff] = mlq_pkg::NIL;
            tail_in[lvl_ff] = mlq_pkg::NIL;
         end
         mlq_pkg::OP_ROTATE: begin
            wa_en   = 1'b1;
            wa_addr = tail_sel;
            wa_data = cur_ff;
            tail_in[lvl_ff] = cur_ff;
            head_in[lvl_ff] = lnk;
            wb_en   = 1'b1;
            wb_addr = cur_ff;
         end
         mlq_pkg::OP_STEP: begin
            prev_in = cur_ff;
            cur_in  = lnk;
            cnt_in  = cnt_ff + 1'b1;
         end
         mlq_pkg::OP_CUT_TAIL: begin
            res_in          = tail_sel;
            tail_in[lvl_ff] = cur_ff;
            wa_en   = 1'b1;
            wa_addr = cur_ff;
            wb_en   = 1'b1;
            wb_addr = tail_sel;
         end
         mlq_pkg::OP_UNLINK: begin
            wa_en   = 1'b1;
            wa_addr = prev_ff;
            wa_data = lnk;
            if (lnk == mlq_pkg::NIL) begin
               tail_in[lvl_ff] = prev_ff;
            end
            wb_en   = 1'b1;
            wb_addr = cur_ff;
            res_in  = cur_ff;
         end
         mlq_pkg::OP_SCAN: begin
            lvl_in   = scan_idx;
            found_in = scan_hit ? mlq_pkg::FOUND_W'(scan_idx)
                                : mlq_pkg::FOUND_W'(mlq_pkg::NUM_LEVELS);
            cur_in   = scan_hit ? head_ff[scan_idx] : mlq_pkg::NIL;
         end
         mlq_pkg::OP_PEEK: begin
            res_in = cur_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mlq_pkg::NUM_LEVELS; i++) begin
            head_ff[i] <= mlq_pkg::NIL;
            tail_ff[i] <= mlq_pkg::NIL;
         end
         strobe_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         strobe_ff <= ctrl.rsp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wa_en && wa_addr < mlq_pkg::NIL) begin
         link_ff[wa_addr[IW-1:0]] <= wa_data;
      end
      if (wb_en && wb_addr < mlq_pkg::NIL) begin
         link_ff[wb_addr[IW-1:0]] <= wb_data;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      lvl_ff   <= lvl_in;
      lv_ok_ff <= lv_ok_in;
      node_ff  <= node_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      cnt_ff   <= cnt_in;
      res_ff   <= res_in;
      found_ff <= found_in;
      if (ctrl.rsp_valid) begin
         status_ff <= ctrl.rsp_status;
         if (ctrl.rsp_status == mlq_pkg::STATUS_OK && res_in != mlq_pkg::NIL) begin
            node_out_ff <= mlq_pkg::NODE_W'(res_in);
         end else begin
            node_out_ff <= '0;
         end
         if (cmd_ff == mlq_pkg::CMD_PEEK_HIGH || cmd_ff == mlq_pkg::CMD_POP_HIGH) begin
            level_out_ff <= mlq_pkg::LVOUT_W'(found_ff);
         end else begin
            level_out_ff <= '0;
         end
      end
   end

   assign stat.cmd          = cmd_ff;
   assign stat.lv_ok        = lv_ok_ff;
   assign stat.node_ok      = node_ok;
   assign stat.node_eq_tail = node_p == tail_sel;
   assign stat.head_nil     = head_sel == mlq_pkg::NIL;
   assign stat.tail_nil     = tail_sel == mlq_pkg::NIL;
   assign stat.head_eq_tail = head_sel == tail_sel;
   assign stat.cur_nil      = cur_ff == mlq_pkg::NIL;
   assign stat.cur_eq_node  = cur_ff == node_p;
   assign stat.lnk_eq_tail  = lnk == tail_sel;
   assign stat.prev_nil     = prev_ff == mlq_pkg::NIL;
   assign stat.cnt_done     = 32'(cnt_ff) >= mlq_pkg::NUM_NODES;
   assign stat.scan_hit     = found_ff != mlq_pkg::FOUND_W'(mlq_pkg::NUM_LEVELS);

   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_node_out  = node_out_ff;
   assign rsp_level_out = level_out_ff;

endmodule

[hw/rtl/mlq_controller.sv]
// Controller of the multi-level linked task queue: sequences each transaction
// and issues datapath operations. Uses mlq_pkg.
module mlq_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mlq_pkg::dp_stat_type  stat,
   output mlq_pkg::ctrl_cmd_type ctrl
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_DECIDE    = 5'b00010,
      ST_WALK_TAIL = 5'b00100,
      ST_WALK_RM   = 5'b01000,
      ST_PICK      = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   task automatic respond(input mlq_pkg::op_type op, input mlq_pkg::status_type st);
      ctrl.op         = op;
      ctrl.rsp_valid  = 1'b1;
      ctrl.rsp_status = st;
      state_in        = ST_IDLE;
   endtask

   always_comb begin
      state_in        = state_ff;
      ctrl.op         = mlq_pkg::OP_NONE;
      ctrl.rsp_valid  = 1'b0;
      ctrl.rsp_status = mlq_pkg::STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.op  = mlq_pkg::OP_LOAD;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            unique case (stat.cmd) inside
               mlq_pkg::CMD_PUSH_TAIL, mlq_pkg::CMD_PUSH_HEAD: begin
                  if (!stat.lv_ok || !stat.node_ok || stat.node_eq_tail) begin
                     respond(mlq_pkg::OP_NONE, mlq_pkg::STATUS_REFUSED);
                  end else if (stat.cmd == mlq_pkg::CMD_PUSH_TAIL) begin
                     respond(mlq_pkg::OP_PUSH_TAIL, mlq_pkg::STATUS_OK);
                  end else begin
                     respond(mlq_pkg::OP_PUSH_HEAD, mlq_pkg::STATUS_OK);
                  end
               end
               mlq_pkg::CMD_POP_HEAD: begin
                  if (!stat.lv_ok || stat.cur_nil) begin
                     respond(mlq_pkg::OP_NONE, mlq_pkg::STATUS_EMPTY);
                  end else begin
                     respond(mlq_pkg::OP_TAKE, mlq_pkg::STATUS_OK);
                  end
               end
               mlq_pkg::CMD_POP_TAIL: begin
                  if (!stat.lv_ok || stat.tail_nil) begin
                     respond(mlq_pkg::OP_NONE, mlq_pkg::STATUS_EMPTY);
                  end else if (stat.head_eq_tail) begin
                     respond(mlq_pkg::OP_POP_ONLY, mlq_pkg::STATUS_OK);
                  end else begin
                     state_in = ST_WALK_TAIL;
                  end
               end
               mlq_pkg::CMD_ROTATE: begin
                  if (!stat.lv_ok || stat.head_nil || stat.tail_nil) begin
                     respond(mlq_pkg::OP_NONE, mlq_pkg::STATUS_EMPTY);
                  end else if (!stat.head_eq_tail) begin
                     respond(mlq_pkg::OP_ROTATE, mlq_pkg::STATUS_OK);
                  end else begin
                     respond(mlq_pkg::OP_NONE, mlq_pkg::STATUS_OK);
                  end
               end
               mlq_pkg::CMD_REMOVE: begin
                  if (!stat.lv_ok || !stat.node_ok) begin
                     respond(mlq_pkg::OP_NONE, mlq_pkg::STATUS_EMPTY);
                  end else begin
                     state_in = ST_WALK_RM;
                  end
               end
               default: begin
                  ctrl.op  = mlq_pkg::OP_SCAN;
                  state_in = ST_PICK;
               end
            endcase
         end
         ST_WALK_TAIL: begin
            if (stat.cur_nil || stat.cnt_done) begin
               respond(mlq_pkg::OP_NONE, mlq_pkg::STATUS_EMPTY);
            end else if (stat.lnk_eq_tail) begin
               respond(mlq_pkg::OP_CUT_TAIL, mlq_pkg::STATUS_OK);
            end else begin
               ctrl.op = mlq_pkg::OP_STEP;
            end
         end
         ST_WALK_RM: begin
            if (stat.cur_nil || stat.cnt_done) begin
               respond(mlq_pkg::OP_NONE, mlq_pkg::STATUS_EMPTY);
            end else if (stat.cur_eq_node) begin
               if (stat.prev_nil) begin
                  respond(mlq_pkg::OP_TAKE, mlq_pkg::STATUS_OK);
               end else begin
                  respond(mlq_pkg::OP_UNLINK, mlq_pkg::STATUS_OK);
               end
            end else begin
               ctrl.op = mlq_pkg::OP_STEP;
            end
         end
         ST_PICK: begin
            if (!stat.scan_hit) begin
               respond(mlq_pkg::OP_NONE, mlq_pkg::STATUS_EMPTY);
            end else if (stat.cmd == mlq_pkg::CMD_PEEK_HIGH) begin
               respond(mlq_pkg::OP_PEEK, mlq_pkg::STATUS_OK);
            end else begin
               respond(mlq_pkg::OP_TAKE, mlq_pkg::STATUS_OK);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

[hw/rtl/multi_level_linked_task_queue.sv]
// Multi-level linked task queue: eight priority FIFO queues of sixteen nodes,
// threaded through a shared next-link store. Every transaction returns exactly
// one result, shown for one cycle with rsp_strobe high; the receiver cannot
// stall it, so capture it on that cycle. Issue a transaction with start while
// busy is low. Push, pop head and rotate respond from the decide state; the peek
// or pop of the first non-empty level responds from the pick state after a scan.
// Pop tail and remove walk the list one link per cycle through the single read
// port of the link store. busy drops as the result is registered, so a new
// transaction may be taken in the cycle the strobe shows.
// Depends on mlq_pkg, mlq_controller and mlq_datapath.
module multi_level_linked_task_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [mlq_pkg::CMD_W-1:0]    req_cmd,
   input  logic [mlq_pkg::LEVEL_W-1:0]  req_queue_level,
   input  logic [mlq_pkg::NODE_W-1:0]   req_node_id,
   output logic                         rsp_strobe,
   output logic [mlq_pkg::STATUS_W-1:0] rsp_status,
   output logic [mlq_pkg::NODE_W-1:0]   rsp_node_out,
   output logic [mlq_pkg::LVOUT_W-1:0]  rsp_level_out
);

   mlq_pkg::ctrl_cmd_type ctrl;
   mlq_pkg::dp_stat_type  stat;

   mlq_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   mlq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_queue_level (req_queue_level),
      .req_node_id     (req_node_id),
      .ctrl            (ctrl),
      .stat            (stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_node_out    (rsp_node_out),
      .rsp_level_out   (rsp_level_out)
   );

endmodule
